// ----- rtl/ogn_pkg.sv -----
// shared types, constants and the table function for the octave gradient noise block
package ogn_pkg;

   // default values of the top level parameters
   localparam int GRID_MAX_DEF       = 64;
   localparam int OCTAVES_MAX_DEF    = 4;
   localparam int COS_TABLE_BITS_DEF = 8;

   // words per octave table and its address width
   localparam int TABLE_WORDS = 8192;
   localparam int TABLE_AW    = 13;

   // datapath widths
   localparam int VAL_W = 18;
   localparam int SUM_W = 26;
   localparam int MU_W  = 13;

   // fixed point constants
   localparam logic [15:0]        ONE_Q12     = 16'd4096;
   localparam logic signed [12:0] NEG_ONE_Q12 = 13'sh1000;
   localparam logic signed [SUM_W-1:0] HEIGHT_MAX = SUM_W'(1048575);
   localparam logic signed [SUM_W-1:0] HEIGHT_MIN = -(SUM_W'(1048576));
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_BASE_SIZE    = 2'd0;
   localparam logic [1:0] CSR_OCTAVE_COUNT = 2'd1;
   localparam logic [1:0] CSR_FREQUENCY    = 2'd2;
   localparam logic [1:0] CSR_AMPLITUDE    = 2'd3;

   // request word
   typedef struct packed {
      logic               mode;
      logic [15:0]        coord_x;
      logic [15:0]        coord_y;
      logic [1:0]         table_octave;
      logic [12:0]        table_address;
      logic signed [15:0] gradient_word;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [20:0] height;
      logic               out_of_range;
   } rsp_word_type;

   // one entry of the (1-cos(pi*w))/2 table, Q.12, evaluated at elaboration
   function automatic logic [MU_W-1:0] cos_entry(input int unsigned k, input int unsigned bits);
      int unsigned     n;
      int unsigned     kk;
      logic            mirror;
      longint unsigned wq, x, x2, x3, x5, s, sq, e;
      n      = 32'd1 << bits;
      mirror = (2 * k) > n;
      kk     = mirror ? (n - k) : k;
      wq     = longint'(kk) << (30 - bits);
      x      = (wq * PI_HALF_Q30) >> 30;
      x2     = (x * x) >> 30;
      x3     = (x2 * x) >> 30;
      x5     = (x3 * x2) >> 30;
      s      = x - x3 / 6 + x5 / 120;
      sq     = (s * s) >> 30;
      e      = (sq + (64'd1 << 17)) >> 18;
      if (mirror) begin
         e = 64'd4096 - e;
      end
      return MU_W'(e);
   endfunction

endpackage

// ----- rtl/ogn_grad_mem.sv -----
// gradient word memory, one write port and one registered read port
module ogn_grad_mem #(
   parameter int OCTAVES_MAX = ogn_pkg::OCTAVES_MAX_DEF,
   parameter int MAW = $clog2(OCTAVES_MAX * ogn_pkg::TABLE_WORDS)
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [MAW-1:0] wr_addr,
   input  logic [15:0]    wr_data,
   input  logic           rd_en,
   input  logic [MAW-1:0] rd_addr,
   output logic [15:0]    rd_data
);

   localparam int DEPTH = OCTAVES_MAX * ogn_pkg::TABLE_WORDS;

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ogn_cos_rom.sv -----
// cosine interpolation table, (1-cos(pi*w))/2 in Q.12
module ogn_cos_rom #(
   parameter int COS_TABLE_BITS = ogn_pkg::COS_TABLE_BITS_DEF
) (
   input  logic [COS_TABLE_BITS-1:0]   idx,
   output logic [ogn_pkg::MU_W-1:0]    mu
);

   localparam int ENTRIES = 1 << COS_TABLE_BITS;

   logic [ogn_pkg::MU_W-1:0] rom [ENTRIES];

   // constant entries
   for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
      assign rom[k] = ogn_pkg::cos_entry(k, COS_TABLE_BITS);
   end

   assign mu = rom[idx];

endmodule

// ----- rtl/octave_gradient_noise.sv -----
// Fractal 2D gradient noise summed over octaves.
// Request channel (req_valid / req_stall / req_word): mode 0 writes one gradient
// word into the table of one octave; mode 1 evaluates the noise at a point.
// Response channel (rsp_valid / rsp_stall / rsp_word): one word per request,
// height 0 for a load, out_of_range set when a stride or corner leaves the table.
// Configuration (csr_wr_en / csr_index / csr_data) is to be written while idle;
// the block itself does not enforce it. A load goes from accept to ST_DONE. An
// evaluation runs, per octave (octave_count, capped at OCTAVES_MAX), ST_P1 to
// ST_P3 and the read phase: the eight gradient reads of an octave go one per
// cycle through the single memory read port, then the three blends, the weighted
// add and two Q4.12 factor updates each use the one multiplier of their cycle.
// An out of range octave ends the evaluation at its range check in ST_P3.
// One request is worked at a time; the next is taken once the previous result
// sits in the output register, even while the receiver stalls it.
// Reset clears control and restores the register defaults; the gradient memory
// is not cleared and must be loaded before it is read.
module octave_gradient_noise #(
   parameter int GRID_MAX       = ogn_pkg::GRID_MAX_DEF,
   parameter int OCTAVES_MAX    = ogn_pkg::OCTAVES_MAX_DEF,
   parameter int COS_TABLE_BITS = ogn_pkg::COS_TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ogn_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ogn_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

   localparam int OI    = (OCTAVES_MAX > 1) ? $clog2(OCTAVES_MAX) : 1;
   localparam int CW    = $clog2(OCTAVES_MAX + 1);
   localparam int MAW   = $clog2(OCTAVES_MAX * ogn_pkg::TABLE_WORDS);
   localparam int VAL_W = ogn_pkg::VAL_W;
   localparam int SUM_W = ogn_pkg::SUM_W;
   localparam int MU_W  = ogn_pkg::MU_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_P1, ST_P2, ST_P3, ST_RD, ST_B0, ST_B1, ST_B2,
      ST_W, ST_U, ST_V, ST_FIN, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [6:0]  base_ff;
   logic [2:0]  octs_ff;
   logic [15:0] freq_ff;
   logic [15:0] amp_ff;

   // evaluation registers
   logic [15:0]             cx_ff, cy_ff;
   logic [CW-1:0]           cnt_ff;
   logic [OI-1:0]           oct_ff;
   logic [15:0]             scale_ff, weight_ff;
   logic [23:0]             px_ff, py_ff;
   logic [10:0]             stride_ff;
   logic [21:0]             sq_ff;
   logic [12:0]             row_ff;
   logic [3:0]              rd_cnt_ff;
   logic signed [28:0]      prod_ff;
   logic signed [VAL_W-1:0] n_ff [4];
   logic signed [VAL_W-1:0] r0_ff, r1_ff, v_ff;
   logic signed [SUM_W-1:0] sum_ff;
   ogn_pkg::rsp_word_type   res_ff;
   logic                    rsp_valid_ff;
   ogn_pkg::rsp_word_type   rsp_word_ff;

   // combinational values
   logic                     req_take;
   logic [CW-1:0]            cnt_in;
   logic                     wr_en_in;
   logic [MAW-1:0]           wr_addr_in;
   logic                     rd_en_in;
   logic [2:0]               rd_tag;
   logic [12:0]              rd_off_in;
   logic [MAW-1:0]           rd_addr_in;
   logic [15:0]              rd_data;
   logic [2:0]               pt;
   logic signed [12:0]       dx_in, dy_in, dop_in;
   logic signed [28:0]       mprod_in;
   logic signed [29:0]       dsum_in;
   logic [COS_TABLE_BITS-1:0] mu_idx;
   logic [MU_W-1:0]          mu;
   logic signed [VAL_W-1:0]  bl_a0, bl_a1, bl_out;
   logic signed [VAL_W:0]    bl_diff;
   logic signed [VAL_W+14:0] bl_prod;
   logic signed [34:0]       wprod_in;
   logic [31:0]              scale_prod, weight_prod;
   logic                     bad_in;
   logic [22:0]              row_in;
   logic                     out_free;
   logic                     last_oct;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_in    = (32'(octs_ff) > OCTAVES_MAX) ? CW'(OCTAVES_MAX) : CW'(octs_ff);
   assign last_oct  = (32'(oct_ff) + 32'd1) == 32'(cnt_ff);

   // gradient load path
   assign wr_en_in   = req_take && (req_word.mode == ogn_pkg::MODE_LOAD) &&
                       (32'(req_word.table_octave) < OCTAVES_MAX);
   assign wr_addr_in = MAW'({req_word.table_octave, req_word.table_address});

   // corner read address: bit 0 plane, bit 1 next column, bit 2 next row
   assign rd_tag     = rd_cnt_ff[2:0];
   assign rd_en_in   = (state_ff == ST_RD) && !rd_cnt_ff[3];
   assign rd_off_in  = row_ff + 13'(rd_tag[1]) + (rd_tag[2] ? 13'(stride_ff) : 13'd0) +
                       (rd_tag[0] ? 13'(sq_ff) : 13'd0);
   assign rd_addr_in = MAW'({oct_ff, rd_off_in});

   ogn_grad_mem #(
      .OCTAVES_MAX(OCTAVES_MAX),
      .MAW        (MAW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en_in),
      .wr_addr(wr_addr_in),
      .wr_data(req_word.gradient_word),
      .rd_en  (rd_en_in),
      .rd_addr(rd_addr_in),
      .rd_data(rd_data)
   );

   // dot product of returning gradient word with its corner offset
   assign pt       = 3'(rd_cnt_ff - 4'd1);
   assign dx_in    = $signed({1'b0, px_ff[11:0]}) + (pt[1] ? ogn_pkg::NEG_ONE_Q12 : 13'sd0);
   assign dy_in    = $signed({1'b0, py_ff[11:0]}) + (pt[2] ? ogn_pkg::NEG_ONE_Q12 : 13'sd0);
   assign dop_in   = pt[0] ? dy_in : dx_in;
   assign mprod_in = dop_in * $signed(rd_data);
   assign dsum_in  = 30'(prod_ff) + 30'(mprod_in);

   // blend unit: a0 + floor((a1-a0)*mu / 4096)
   assign mu_idx = (state_ff == ST_B2) ? py_ff[11 -: COS_TABLE_BITS]
                                       : px_ff[11 -: COS_TABLE_BITS];

   ogn_cos_rom #(
      .COS_TABLE_BITS(COS_TABLE_BITS)
   ) u_rom (
      .idx(mu_idx),
      .mu (mu)
   );

   always_comb begin
      case (state_ff)
         ST_B0: begin
            bl_a0 = n_ff[0];
            bl_a1 = n_ff[1];
         end
         ST_B1: begin
            bl_a0 = n_ff[2];
            bl_a1 = n_ff[3];
         end
         default: begin
            bl_a0 = r0_ff;
            bl_a1 = r1_ff;
         end
      endcase
   end

   assign bl_diff = (VAL_W+1)'(bl_a1) - (VAL_W+1)'(bl_a0);
   assign bl_prod = bl_diff * $signed({1'b0, mu});
   assign bl_out  = VAL_W'(bl_prod >>> 12) + bl_a0;

   // weighting and factor updates
   assign wprod_in    = v_ff * $signed({1'b0, weight_ff});
   assign scale_prod  = 32'(scale_ff) * 32'(freq_ff);
   assign weight_prod = 32'(weight_ff) * 32'(amp_ff);

   // range checks and base address of the cell
   assign row_in = 23'(py_ff[23:12]) * 23'(stride_ff) + 23'(px_ff[23:12]);
   assign bad_in = (stride_ff == 11'd0) || (32'(stride_ff) > GRID_MAX) ||
                   (sq_ff > 22'd4096) ||
                   (({1'b0, px_ff[23:12]} + 13'd1) >= 13'(stride_ff)) ||
                   (({1'b0, py_ff[23:12]} + 13'd1) >= 13'(stride_ff));

   // sequencer with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_cnt_ff    <= 4'd0;
         base_ff      <= 7'd8;
         octs_ff      <= 3'd1;
         freq_ff      <= 16'd8192;
         amp_ff       <= 16'd2048;
      end else begin
         // configuration writes
         if (csr_wr_en) begin
            case (csr_index)
               ogn_pkg::CSR_BASE_SIZE:    base_ff <= csr_data[6:0];
               ogn_pkg::CSR_OCTAVE_COUNT: octs_ff <= csr_data[2:0];
               ogn_pkg::CSR_FREQUENCY:    freq_ff <= csr_data;
               ogn_pkg::CSR_AMPLITUDE:    amp_ff  <= csr_data;
               default: ;
            endcase
         end

         // output register drains unless a new result moves in
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cx_ff     <= req_word.coord_x;
                  cy_ff     <= req_word.coord_y;
                  cnt_ff    <= cnt_in;
                  oct_ff    <= '0;
                  scale_ff  <= ogn_pkg::ONE_Q12;
                  weight_ff <= ogn_pkg::ONE_Q12;
                  sum_ff    <= '0;
                  res_ff    <= '0;
                  if (req_word.mode == ogn_pkg::MODE_LOAD || cnt_in == '0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_P1;
                  end
               end
            end
            ST_P1: begin
               px_ff     <= 24'((32'(cx_ff) * 32'(scale_ff)) >> 8);
               stride_ff <= 11'(base_ff) * 11'(scale_ff[15:12]);
               state_ff  <= ST_P2;
            end
            ST_P2: begin
               py_ff    <= 24'((32'(cy_ff) * 32'(scale_ff)) >> 8);
               sq_ff    <= 22'(stride_ff) * 22'(stride_ff);
               state_ff <= ST_P3;
            end
            ST_P3: begin
               row_ff    <= row_in[12:0];
               rd_cnt_ff <= 4'd0;
               if (bad_in) begin
                  res_ff.height       <= '0;
                  res_ff.out_of_range <= 1'b1;
                  state_ff            <= ST_DONE;
               end else begin
                  state_ff <= ST_RD;
               end
            end
            ST_RD: begin
               if (rd_cnt_ff != 4'd0) begin
                  if (!pt[0]) begin
                     prod_ff <= mprod_in;
                  end else begin
                     n_ff[pt[2:1]] <= VAL_W'(dsum_in >>> 14);
                  end
               end
               rd_cnt_ff <= rd_cnt_ff + 4'd1;
               if (rd_cnt_ff[3]) begin
                  state_ff <= ST_B0;
               end
            end
            ST_B0: begin
               r0_ff    <= bl_out;
               state_ff <= ST_B1;
            end
            ST_B1: begin
               r1_ff    <= bl_out;
               state_ff <= ST_B2;
            end
            ST_B2: begin
               v_ff     <= bl_out;
               state_ff <= ST_W;
            end
            ST_W: begin
               sum_ff   <= sum_ff + SUM_W'(wprod_in >>> 12);
               state_ff <= ST_U;
            end
            ST_U: begin
               scale_ff <= (scale_prod[31:28] != 4'd0) ? 16'hFFFF : scale_prod[27:12];
               state_ff <= ST_V;
            end
            ST_V: begin
               weight_ff <= (weight_prod[31:28] != 4'd0) ? 16'hFFFF : weight_prod[27:12];
               oct_ff    <= OI'(32'(oct_ff) + 32'd1);
               state_ff  <= last_oct ? ST_FIN : ST_P1;
            end
            ST_FIN: begin
               // saturate the total
               if (sum_ff > ogn_pkg::HEIGHT_MAX) begin
                  res_ff.height <= 21'(ogn_pkg::HEIGHT_MAX);
               end else if (sum_ff < ogn_pkg::HEIGHT_MIN) begin
                  res_ff.height <= 21'(ogn_pkg::HEIGHT_MIN);
               end else begin
                  res_ff.height <= 21'(sum_ff);
               end
               res_ff.out_of_range <= 1'b0;
               state_ff            <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_word_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // an accepted request always leaves idle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // the eighth gradient word is consumed before blending starts
   a_rd_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD && rd_cnt_ff[3]) |=> state_ff == ST_B0)
      else $error("read phase did not hand over to blending");

   // a zero stride ends the evaluation with out_of_range
   a_zero_stride: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P3 && stride_ff == 11'd0) |=>
      (state_ff == ST_DONE && res_ff.out_of_range))
      else $error("zero stride not flagged");

   // a finished result is moved into a free output register
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not delivered to the output register");

   // the memory is never read outside the read phase
   a_read_phase: assert property (@(posedge clock) disable iff (reset)
      rd_en_in |-> (state_ff == ST_RD && rd_cnt_ff < 4'd8))
      else $error("gradient read outside read phase");

endmodule

// ----- tb/tb_octave_gradient_noise.sv -----
// testbench for octave_gradient_noise: directed table, random phases, self-checking predictor
`timescale 1ns / 100ps

module tb_octave_gradient_noise;

   localparam int OCT_N  = 4;
   localparam int GRID_N = 64;

   // one row of the directed table
   typedef struct {
      logic              mode;
      logic [15:0]       cx;
      logic [15:0]       cy;
      logic [1:0]        oct;
      logic [12:0]       addr;
      logic signed [15:0] grad;
      bit                typed;
      logic signed [20:0] height;
      logic              oor;
   } table_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   ogn_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   ogn_pkg::rsp_word_type rsp_word;
   logic                  csr_wr_en;
   logic [1:0]            csr_index;
   logic [15:0]           csr_data;

   // predictor state
   logic [15:0]  grad_mem [OCT_N][ogn_pkg::TABLE_WORDS];
   bit           grad_set [OCT_N][ogn_pkg::TABLE_WORDS];
   logic [6:0]   cfg_base;
   logic [2:0]   cfg_count;
   logic [15:0]  cfg_freq;
   logic [15:0]  cfg_amp;

   ogn_pkg::req_word_type send_queue[$];
   ogn_pkg::rsp_word_type height_queue[$];
   int           error_count;
   int           words_out;
   int           words_in;

   octave_gradient_noise i_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // raised cosine ramp, Q.12
   function automatic longint cos_ramp(input int unsigned k);
      longint unsigned wq, x, x2, x3, x5, s, sq;
      if (2 * k > (1 << 8)) begin
         return 64'sd4096 - cos_ramp((1 << 8) - k);
      end
      wq = longint'(k) << 22;
      x  = (wq * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      x3 = (x2 * x) >> 30;
      x5 = (x3 * x2) >> 30;
      s  = x - x3 / 6 + x5 / 120;
      sq = (s * s) >> 30;
      return longint'((sq + (64'd1 << 17)) >> 18);
   endfunction

   function automatic longint mix(input longint a0, input longint a1, input longint w);
      longint mu;
      mu = cos_ramp(int'(w >> 4));
      return (a0 * (64'sd4096 - mu) + a1 * mu) >>> 12;
   endfunction

   function automatic logic [15:0] q12_mul_sat(input logic [15:0] a, input logic [15:0] b);
      longint unsigned p;
      p = (longint'(a) * longint'(b)) >> 12;
      return (p > 65535) ? 16'hFFFF : p[15:0];
   endfunction

   // queue one word with its expected result
   task automatic push_word(input ogn_pkg::req_word_type w, input ogn_pkg::rsp_word_type r);
      send_queue.push_back(w);
      height_queue.push_back(r);
      words_in++;
   endtask

   task automatic push_load(input logic [1:0] oct, input logic [12:0] addr,
                            input logic signed [15:0] g);
      ogn_pkg::req_word_type w;
      ogn_pkg::rsp_word_type r;
      w = '0;
      w.mode = ogn_pkg::MODE_LOAD;
      w.table_octave = oct;
      w.table_address = addr;
      w.gradient_word = g;
      w.coord_x = 16'($urandom);
      w.coord_y = 16'($urandom);
      r = '0;
      grad_mem[oct][addr] = g;
      grad_set[oct][addr] = 1'b1;
      push_word(w, r);
   endtask

   // gradient read; an unwritten word gets loaded first with random content
   task automatic fetch_grad(input int oct, input longint a, output longint g);
      logic [12:0] addr;
      addr = 13'(a);
      if (!grad_set[oct][addr]) begin
         push_load(2'(oct), addr, 16'(int'($urandom_range(0, 32768)) - 16384));
      end
      g = longint'($signed(grad_mem[oct][addr]));
   endtask

   task automatic corner(input int oct, input longint stride, input longint ix,
                         input longint iy, input longint dx, input longint dy,
                         output longint d);
      longint a, gx, gy;
      a = ix + iy * stride;
      fetch_grad(oct, a, gx);
      fetch_grad(oct, a + stride * stride, gy);
      d = (dx * gx + dy * gy) >>> 14;
   endtask

   // fractal sum at one point; loads any gradient it needs ahead of the evaluation
   task automatic noise_sum(input logic [15:0] cx, input logic [15:0] cy,
                            output ogn_pkg::rsp_word_type r);
      longint stride, px, py, x0, y0, sx, sy, n0, n1, r0, r1, v, sum;
      logic [15:0] scale, weight;
      int count;
      bit bad;
      scale = ogn_pkg::ONE_Q12;
      weight = ogn_pkg::ONE_Q12;
      sum = 0;
      bad = 1'b0;
      count = (cfg_count > OCT_N) ? OCT_N : int'(cfg_count);
      for (int i = 0; i < count; i++) begin
         stride = longint'(cfg_base) * longint'(scale >> 12);
         px = (longint'(cx) * longint'(scale)) >> 8;
         py = (longint'(cy) * longint'(scale)) >> 8;
         x0 = px >> 12;
         y0 = py >> 12;
         sx = px & 12'hFFF;
         sy = py & 12'hFFF;
         if (stride == 0 || stride > GRID_N ||
             2 * stride * stride > ogn_pkg::TABLE_WORDS ||
             x0 + 1 >= stride || y0 + 1 >= stride) begin
            bad = 1'b1;
            break;
         end
         corner(i, stride, x0, y0, sx, sy, n0);
         corner(i, stride, x0 + 1, y0, sx - 4096, sy, n1);
         r0 = mix(n0, n1, sx);
         corner(i, stride, x0, y0 + 1, sx, sy - 4096, n0);
         corner(i, stride, x0 + 1, y0 + 1, sx - 4096, sy - 4096, n1);
         r1 = mix(n0, n1, sx);
         v = mix(r0, r1, sy);
         sum += (v * longint'(weight)) >>> 12;
         scale = q12_mul_sat(scale, cfg_freq);
         weight = q12_mul_sat(weight, cfg_amp);
      end
      r = '0;
      if (bad) begin
         r.out_of_range = 1'b1;
      end else begin
         if (sum > 1048575) sum = 1048575;
         if (sum < -1048576) sum = -1048576;
         r.height = 21'(sum);
      end
   endtask

   task automatic push_eval(input logic [15:0] cx, input logic [15:0] cy);
      ogn_pkg::req_word_type w;
      ogn_pkg::rsp_word_type r;
      noise_sum(cx, cy, r);
      w = '0;
      w.mode = ogn_pkg::MODE_EVAL;
      w.coord_x = cx;
      w.coord_y = cy;
      w.table_octave = 2'($urandom);
      w.table_address = 13'($urandom);
      w.gradient_word = 16'($urandom);
      push_word(w, r);
   endtask

   // wait for every expected word, then let the block settle
   task automatic wait_idle();
      while (send_queue.size() != 0 || height_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic write_regs(input logic [6:0] base, input logic [2:0] count,
                             input logic [15:0] freq, input logic [15:0] amp);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= ogn_pkg::CSR_BASE_SIZE;
      csr_data  <= 16'(base);
      @(posedge clock);
      csr_index <= ogn_pkg::CSR_OCTAVE_COUNT;
      csr_data  <= 16'(count);
      @(posedge clock);
      csr_index <= ogn_pkg::CSR_FREQUENCY;
      csr_data  <= freq;
      @(posedge clock);
      csr_index <= ogn_pkg::CSR_AMPLITUDE;
      csr_data  <= amp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_base  = base;
      cfg_count = count;
      cfg_freq  = freq;
      cfg_amp   = amp;
   endtask

   // one phase of random words under the current settings
   task automatic random_phase(input int n);
      int start;
      int span;
      start = words_in;
      span = (cfg_base > 1) ? (int'(cfg_base) - 1) * 256 - 1 : 255;
      while (words_in - start < n) begin
         case ($urandom_range(0, 9))
            0: push_load(2'($urandom), 13'($urandom),
                         16'(int'($urandom_range(0, 32768)) - 16384));
            1: push_eval(16'($urandom), 16'($urandom));
            default: push_eval(16'($urandom_range(0, span)), 16'($urandom_range(0, span)));
         endcase
      end
   endtask

   // sender: bursts of words with random gaps
   initial begin
      int burst;
      int gap;
      req_valid <= 1'b0;
      req_word  <= '0;
      burst = 0;
      gap = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            void'(send_queue.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (send_queue.size() > (req_valid && !req_stall ? 0 : 0) && gap == 0 &&
                send_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_word  <= send_queue[0];
               if (burst == 0) begin
                  burst = $urandom_range(1, 24);
               end
               burst--;
               if (burst == 0) begin
                  gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
               if (gap > 0) gap--;
            end
         end
      end
   end

   // receiver: stall pattern of its own, with one long hold-off
   initial begin
      int stall_pct;
      int tick;
      int hold;
      bit held;
      rsp_stall <= 1'b0;
      stall_pct = 0;
      tick = 0;
      hold = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 250 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         if (!held && words_out >= 400) begin
            held = 1'b1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      ogn_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (height_queue.size() == 0) begin
            $error("unexpected word: height %0d out_of_range %0b",
                   rsp_word.height, rsp_word.out_of_range);
            error_count++;
         end else begin
            want = height_queue.pop_front();
            if (rsp_word.height !== want.height) begin
               $error("height: expected %0d, got %0d", want.height, rsp_word.height);
               error_count++;
            end
            if (rsp_word.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0b, got %0b",
                      want.out_of_range, rsp_word.out_of_range);
               error_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      table_row_type rows[$];
      ogn_pkg::rsp_word_type r;
      ogn_pkg::req_word_type w;
      error_count = 0;
      words_out = 0;
      words_in = 0;
      reset = 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= ogn_pkg::CSR_BASE_SIZE;
      csr_data  <= '0;
      cfg_base  = 7'd8;
      cfg_count = 3'd1;
      cfg_freq  = 16'd8192;
      cfg_amp   = 16'd2048;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows under reset settings
      rows = '{
         '{ogn_pkg::MODE_LOAD, 16'h0000, 16'h0000, 2'd0, 13'd0, 16'sd16384,
           1'b1, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_LOAD, 16'hFFFF, 16'hFFFF, 2'd3, 13'd8191, -16'sd16384,
           1'b1, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_LOAD, 16'h5555, 16'hAAAA, 2'd2, 13'h1555, 16'sd10922,
           1'b1, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_LOAD, 16'hAAAA, 16'h5555, 2'd1, 13'h0AAA, -16'sd10923,
           1'b1, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_EVAL, 16'hFFFF, 16'h0000, 2'd0, 13'd0, 16'sd0,
           1'b1, 21'sd0, 1'b1},
         '{ogn_pkg::MODE_EVAL, 16'h0000, 16'hFFFF, 2'd3, 13'd8191, -16'sd1,
           1'b1, 21'sd0, 1'b1},
         '{ogn_pkg::MODE_EVAL, 16'h0700, 16'h0000, 2'd0, 13'd0, 16'sd0,
           1'b1, 21'sd0, 1'b1},
         '{ogn_pkg::MODE_EVAL, 16'h0000, 16'h0000, 2'd0, 13'd0, 16'sd0,
           1'b0, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_EVAL, 16'h06FF, 16'h06FF, 2'd0, 13'd0, 16'sd0,
           1'b0, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_EVAL, 16'h0080, 16'h0600, 2'd0, 13'd0, 16'sd0,
           1'b0, 21'sd0, 1'b0},
         '{ogn_pkg::MODE_EVAL, 16'h0380, 16'h0240, 2'd0, 13'd0, 16'sd0,
           1'b0, 21'sd0, 1'b0}
      };
      foreach (rows[k]) begin
         if (rows[k].typed) begin
            w = '0;
            w.mode = rows[k].mode;
            w.coord_x = rows[k].cx;
            w.coord_y = rows[k].cy;
            w.table_octave = rows[k].oct;
            w.table_address = rows[k].addr;
            w.gradient_word = rows[k].grad;
            r.height = rows[k].height;
            r.out_of_range = rows[k].oor;
            if (rows[k].mode == ogn_pkg::MODE_LOAD) begin
               grad_mem[rows[k].oct][rows[k].addr] = rows[k].grad;
               grad_set[rows[k].oct][rows[k].addr] = 1'b1;
            end
            push_word(w, r);
         end else begin
            push_eval(rows[k].cx, rows[k].cy);
         end
      end

      // settings at the edges: unit grid, zero and excess octave counts, zero and top factors
      wait_idle();
      write_regs(7'd1, 3'd4, 16'd4096, 16'd4096);
      random_phase(12);
      wait_idle();
      write_regs(7'd8, 3'd0, 16'd8192, 16'd2048);
      random_phase(10);
      wait_idle();
      write_regs(7'd4, 3'd7, 16'd8192, 16'd65535);
      random_phase(80);
      wait_idle();
      write_regs(7'd64, 3'd1, 16'd0, 16'd0);
      random_phase(80);
      wait_idle();
      write_regs(7'd8, 3'd2, 16'd0, 16'd65535);
      random_phase(20);
      wait_idle();
      write_regs(7'd2, 3'd2, 16'd65535, 16'd65535);
      random_phase(60);

      // random settings
      for (int p = 0; p < 10; p++) begin
         wait_idle();
         case ($urandom_range(0, 2))
            0: write_regs(7'($urandom_range(1, 64)), 3'($urandom), 16'($urandom),
                          16'($urandom));
            1: write_regs(7'($urandom_range(2, 16)), 3'($urandom_range(1, 4)), 16'd8192,
                          16'($urandom));
            default: write_regs(7'($urandom_range(2, 32)), 3'($urandom_range(1, 2)),
                                16'($urandom_range(4096, 8191)), 16'($urandom));
         endcase
         random_phase(160);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ogn_pkg.sv
rtl/ogn_grad_mem.sv
rtl/ogn_cos_rom.sv
rtl/octave_gradient_noise.sv
tb/tb_octave_gradient_noise.sv
